// ----- rtl/olc_pkg.sv -----
`timescale 1ns / 1ps

package olc_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // width of count and index fields broadcast to cells, enough for 1024 entries
    localparam int CNT_BITS_MAX = 11;

    // request kinds
    typedef enum logic [2:0] {
        KIND_INS_HEAD = 3'd0,
        KIND_INS_TAIL = 3'd1,
        KIND_DROP_AT  = 3'd2,
        KIND_DROP_VAL = 3'd3,
        KIND_PURGE    = 3'd4
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    // per-cell update operation
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_UP   = 3'd1,
        CELL_APPEND     = 3'd2,
        CELL_DROP_AT    = 3'd3,
        CELL_DROP_MATCH = 3'd4
    } cell_op_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  position;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_count;
        logic [5:0] cursor;
        logic [4:0] removed_at;
    } rsp_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t                op;
        logic                    capture;
        logic [CNT_BITS_MAX-1:0] idx;
        logic [CNT_BITS_MAX-1:0] held;
    } cell_cmd_t;

endpackage

// ----- rtl/olc_cell.sv -----
`timescale 1ns / 1ps

module olc_cell
    import olc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_cmd_t             cmd,
    input  logic [VALUE_BITS-1:0] word,
    input  logic [VALUE_BITS-1:0] left_entry,
    input  logic [VALUE_BITS-1:0] right_entry,
    input  logic                  found_in,
    output logic                  found_out,
    output logic                  first,
    output logic [VALUE_BITS-1:0] entry
);

    localparam logic [CNT_BITS_MAX-1:0] MY_INDEX = CNT_BITS_MAX'(INDEX);

    logic [VALUE_BITS-1:0] entry_reg;
    logic [VALUE_BITS-1:0] entry_next;
    logic                  match_reg;

    // priority chain: first match from the head wins
    assign found_out = found_in | match_reg;
    assign first     = match_reg & ~found_in;
    assign entry     = entry_reg;

    // next entry value from the broadcast operation
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_SHIFT_UP:
            begin
                entry_next = left_entry;
            end
            CELL_APPEND:
            begin
                if (MY_INDEX == cmd.held)
                begin
                    entry_next = word;
                end
            end
            CELL_DROP_AT:
            begin
                if (MY_INDEX >= cmd.idx)
                begin
                    entry_next = right_entry;
                end
            end
            CELL_DROP_MATCH:
            begin
                if (found_out)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // stored word
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // compare against the searched word when a request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            match_reg <= (entry_reg == word) && (MY_INDEX < cmd.held);
        end
    end

endmodule

// ----- rtl/ordered_list_with_cursor_top.sv -----
`timescale 1ns / 1ps

// Bounded ordered list of words with an iteration cursor, built as a row of
// CAPACITY cells that each hold one entry and pass words to their neighbors.
// Every request returns one result with status, count, cursor and removed
// index. In the cycle a request is taken every cell compares its entry
// against the request word; then, in the execute state, the match priority
// chain settles, all cells shift in one step and the result register
// loads. A new request can be taken in the cycle after the result loads,
// so no request is taken while the last one is still executing; if the
// result register is still stalled, execution waits until it frees up.
module ordered_list_with_cursor_top
    import olc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 5) ? CW : 5;
    localparam int OW = (CW > 6) ? CW : 6;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t          state_reg;
    req_t            req_reg;
    rsp_t            rsp_reg;
    logic            rsp_valid_reg;
    logic [CW-1:0]   held_reg;
    logic [CW-1:0]   cursor_reg;

    logic                  accept;
    logic                  out_free;
    cell_cmd_t             cmd;
    logic [VALUE_BITS-1:0] word;
    logic [VALUE_BITS-1:0] cell_entry [CAPACITY];
    logic [VALUE_BITS-1:0] left_in    [CAPACITY];
    logic [VALUE_BITS-1:0] right_in   [CAPACITY];
    logic [CAPACITY:0]     found;
    logic [CAPACITY-1:0]   first;

    logic [CW-1:0]   first_idx;
    logic [IW-1:0]   pos_w;
    logic [IW-1:0]   held_w;
    logic [CW-1:0]   drop_idx;
    logic [CW-1:0]   held_dec;
    logic [CW-1:0]   cursor_dec;
    cell_op_t        op_sel;
    status_t         status_sel;
    logic [CW-1:0]   held_next;
    logic [CW-1:0]   cursor_next;
    logic [CW-1:0]   where;
    logic [OW-1:0]   held_out_w;
    logic [OW-1:0]   cursor_out_w;
    logic [IW-1:0]   where_w;
    rsp_t            rsp_next;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // word for compare on the take cycle, for writes on the execute cycle
    assign word = (state_reg == ST_IDLE) ? VALUE_BITS'(req.value)
                                         : VALUE_BITS'(req_reg.value);

    // row of cells
    assign found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_in[g] = word;
        end
        else
        begin : g_mid
            assign left_in[g] = cell_entry[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_in[g] = cell_entry[g];
        end
        else
        begin : g_body
            assign right_in[g] = cell_entry[g+1];
        end

        olc_cell #(
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .word        (word),
            .left_entry  (left_in[g]),
            .right_entry (right_in[g]),
            .found_in    (found[g]),
            .found_out   (found[g+1]),
            .first       (first[g]),
            .entry       (cell_entry[g])
        );
    end

    // index of the first matching cell
    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first[i])
            begin
                first_idx = first_idx | CW'(i);
            end
        end
    end

    // decode the held request
    always_comb
    begin
        pos_w      = IW'(req_reg.position);
        held_w     = IW'(held_reg);
        drop_idx   = (req_reg.kind == KIND_DROP_VAL) ? first_idx : pos_w[CW-1:0];
        held_dec   = held_reg - CW'(1);
        cursor_dec = (drop_idx < cursor_reg) ? (cursor_reg - CW'(1)) : cursor_reg;

        op_sel      = CELL_HOLD;
        status_sel  = STAT_DONE;
        held_next   = held_reg;
        cursor_next = cursor_reg;
        where       = '0;

        case (req_reg.kind)
            KIND_INS_HEAD:
            begin
                if (held_reg == CW'(CAPACITY))
                begin
                    status_sel = STAT_FULL;
                end
                else
                begin
                    op_sel      = CELL_SHIFT_UP;
                    held_next   = held_reg + CW'(1);
                    cursor_next = cursor_reg + CW'(1);
                end
            end
            KIND_INS_TAIL:
            begin
                if (held_reg == CW'(CAPACITY))
                begin
                    status_sel = STAT_FULL;
                end
                else
                begin
                    op_sel    = CELL_APPEND;
                    held_next = held_reg + CW'(1);
                end
            end
            KIND_DROP_AT,
            KIND_DROP_VAL:
            begin
                if ((req_reg.kind == KIND_DROP_AT) && (pos_w >= held_w))
                begin
                    status_sel = STAT_RANGE;
                end
                else if ((req_reg.kind == KIND_DROP_VAL) && !found[CAPACITY])
                begin
                    status_sel = STAT_MISSING;
                end
                else
                begin
                    op_sel      = (req_reg.kind == KIND_DROP_AT) ? CELL_DROP_AT
                                                                 : CELL_DROP_MATCH;
                    held_next   = held_dec;
                    cursor_next = (cursor_dec > held_dec) ? held_dec : cursor_dec;
                    where       = drop_idx;
                end
            end
            KIND_PURGE:
            begin
                held_next   = '0;
                cursor_next = '0;
            end
            default:
            begin
                op_sel = CELL_HOLD;
            end
        endcase

        held_out_w   = OW'(held_next);
        cursor_out_w = OW'(cursor_next);
        where_w      = IW'(where);

        rsp_next.status      = status_sel;
        rsp_next.entry_count = held_out_w[5:0];
        rsp_next.cursor      = cursor_out_w[5:0];
        rsp_next.removed_at  = where_w[4:0];
    end

    // command to the cells
    always_comb
    begin
        cmd.op      = ((state_reg == ST_EXEC) && out_free) ? op_sel : CELL_HOLD;
        cmd.capture = accept;
        cmd.idx     = CNT_BITS_MAX'(drop_idx);
        cmd.held    = CNT_BITS_MAX'(held_reg);
    end

    // control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            held_reg      <= '0;
            cursor_reg    <= '0;
        end
        else
        begin
            // result taken and no new one loading
            if (rsp_valid_reg && !rsp_stall && !((state_reg == ST_EXEC) && out_free))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        held_reg      <= held_next;
                        cursor_reg    <= cursor_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/olc_checker.sv -----
`timescale 1ns / 1ps

module olc_checker
    import olc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    localparam logic [5:0] FULL_COUNT = 6'(CAPACITY);
    localparam logic       SMALL_LIST = (CAPACITY < 64);

    // one request at a time: a taken request blocks the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken on the cycle after another");

    // cursor never runs past the count (checked for capacities below 64)
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL_LIST |-> rsp.cursor <= rsp.entry_count)
        else $error("cursor beyond entry count");

    // a refused insert reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_FULL) |-> rsp.entry_count == FULL_COUNT)
        else $error("full status with list not full");

    // refused or failed removals report no index
    a_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp.status == STAT_RANGE) || (rsp.status == STAT_MISSING))
        |-> rsp.removed_at == 5'd0)
        else $error("removed index on a failed removal");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind ordered_list_with_cursor_top olc_checker #(
    .CAPACITY (CAPACITY)
) u_olc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
